// ===== sv/psec_pkg.sv =====
// shared constants and types for the per-sender event counter table
package psec_pkg;

  // field widths
  localparam int ID_W    = 22;
  localparam int COUNT_W = 32;
  localparam int WORD_W  = ID_W + 2 * COUNT_W;

  // default table depth
  localparam int ENTRIES_DEF = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_DUMP  = 1'b1;

  // event kinds
  localparam logic KIND_FIRST  = 1'b0;
  localparam logic KIND_SECOND = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

endpackage

// ===== sv/psec_cmd_if.sv =====
// command channel: count or dump request
interface psec_cmd_if;
  import psec_pkg::*;

  logic            valid;
  logic            ready;
  logic            operation;
  logic [ID_W-1:0] sender_id;
  logic            event_kind;

  modport source (output valid, operation, sender_id, event_kind, input ready);
  modport sink   (input valid, operation, sender_id, event_kind, output ready);
endinterface

// ===== sv/psec_res_if.sv =====
// result channel: one table entry per item during a dump
interface psec_res_if;
  import psec_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    entry_id;
  logic [COUNT_W-1:0] first_count;
  logic [COUNT_W-1:0] second_count;
  logic               last_entry;

  modport source (output valid, entry_id, first_count, second_count, last_entry,
                  input ready);
  modport sink   (input valid, entry_id, first_count, second_count, last_entry,
                  output ready);
endinterface

// ===== sv/psec_match.sv =====
// sender id lookup over the occupied slots
module psec_match #(
  parameter int ENTRIES = psec_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int FILL_W  = $clog2(ENTRIES + 1)
) (
  input  logic [psec_pkg::ID_W-1:0] ids [ENTRIES],
  input  logic [FILL_W-1:0]         fill,
  input  logic [psec_pkg::ID_W-1:0] key,
  output logic [ENTRIES-1:0]        hit_vec,
  output logic                      hit,
  output logic [IDX_W-1:0]          hit_idx
);
  import psec_pkg::*;

  // compare against every occupied slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (FILL_W'(i) < fill) && (ids[i] == key);
    end
  end

  // ids are unique, so at most one slot matches and an or of indices encodes it
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit = |hit_vec;

endmodule

// ===== sv/per_sender_event_counter_table.sv =====
// top level: per-sender event counter table with dump
//
//  channel | dir | payload                                          | accepted when
//  cmd     | in  | operation, sender_id, event_kind                 | valid && ready
//  res     | out | entry_id, first_count, second_count, last_entry  | valid && ready
//
// a count item is accepted, then goes through id lookup with memory read, then
// saturating increment and write back to the single-port slot memory.
// a dump item visits each slot in turn: memory read, then result held until taken.
// slots fill in order and are never freed, so a fill count marks which memory
// words are valid; no clearing pass is needed after reset.
// a stalled result holds its payload and blocks the next command.
module per_sender_event_counter_table #(
  parameter int ENTRIES = psec_pkg::ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  psec_cmd_if.sink   cmd,
  psec_res_if.source res
);
  import psec_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(ENTRIES);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  state_t state, state_next;

  logic [ID_W-1:0]   ids [ENTRIES];
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  sel;
  logic              rd_ok;
  logic [ID_W-1:0]   req_id;
  logic              req_kind;

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata;
  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               room;
  logic               cmd_fire;
  logic               res_fire;

  logic [COUNT_W-1:0] cur_first;
  logic [COUNT_W-1:0] cur_second;

  psec_match #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .FILL_W  (FILL_W)
  ) u_match (
    .ids     (ids),
    .fill    (fill),
    .key     (req_id),
    .hit_vec (hit_vec),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  assign room     = (fill != FULL);
  assign cmd_fire = cmd.valid && cmd.ready;
  assign res_fire = res.valid && res.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.operation == OP_DUMP) begin
            state_next = S_DUMP_RD;
          end else if (cmd.sender_id != '0) begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        state_next = (hit || room) ? S_UPDATE : S_IDLE;
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (res.ready) begin
          state_next = (idx == LAST_IDX) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd.ready = 1'b0;
    res.valid = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = hit ? hit_idx : fill[IDX_W-1:0];
    unique case (state)
      S_IDLE:     cmd.ready = 1'b1;
      S_LOOKUP:   mem_re = hit || room;
      S_UPDATE:   mem_we = 1'b1;
      S_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx;
      end
      S_DUMP_OUT: res.valid = 1'b1;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fill count and dump index
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
    end else begin
      if (state == S_LOOKUP && !hit && room) begin
        fill <= fill + FILL_W'(1);
      end
      if (state == S_IDLE) begin
        idx <= '0;
      end else if (state == S_DUMP_OUT && res_fire) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // request capture, slot allocation and read qualification
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      req_id   <= cmd.sender_id;
      req_kind <= cmd.event_kind;
    end
    if (state == S_LOOKUP) begin
      sel   <= mem_raddr;
      rd_ok <= hit;
      if (!hit && room) begin
        ids[fill[IDX_W-1:0]] <= req_id;
      end
    end else if (state == S_DUMP_RD) begin
      rd_ok <= (FILL_W'(idx) < fill);
    end
  end

  // counts seen by the update and the dump, zero for a fresh slot
  assign cur_first  = rd_ok ? rdata[COUNT_W-1:0] : '0;
  assign cur_second = rd_ok ? rdata[2*COUNT_W-1:COUNT_W] : '0;

  // saturating increment of the selected counter
  always_comb begin
    mem_wdata = {req_id, cur_second, cur_first};
    if (req_kind == KIND_FIRST) begin
      mem_wdata[COUNT_W-1:0] = sat_inc(cur_first);
    end else begin
      mem_wdata[2*COUNT_W-1:COUNT_W] = sat_inc(cur_second);
    end
  end

  // slot memory, one read or one write per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sel] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // dump result
  assign res.entry_id     = rd_ok ? rdata[WORD_W-1:2*COUNT_W] : '0;
  assign res.first_count  = cur_first;
  assign res.second_count = cur_second;
  assign res.last_entry   = (idx == LAST_IDX);

`ifndef SYNTHESIS
  // no command is taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid))
    else $error("command accepted while a result is pending");

  // writes land only in occupied slots
  a_write_used: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (FILL_W'(sel) < fill))
    else $error("write to an unoccupied slot");

  // the final entry of a dump ends it
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.last_entry) |=> (state == S_IDLE))
    else $error("dump continued past its final entry");

  // sender ids stay unique in the table
  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) |-> $onehot0(hit_vec))
    else $error("sender id held in more than one slot");
`endif

endmodule
